/* hdl/hcp_pkg.sv */
package hcp_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 8;

  localparam int IN_W    = 24;
  localparam int OUT_W   = 21;
  localparam int CFG_W   = 18;
  localparam int ORDER_W = 4;
  localparam int ADDR_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [ADDR_W-1:0] REG_CURVE_ORDER = 2'd0;
  localparam logic [ADDR_W-1:0] REG_FIELD_SIZE  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_CENTER_X    = 2'd2;
  localparam logic [ADDR_W-1:0] REG_CENTER_Y    = 2'd3;

  localparam logic [ORDER_W-1:0] CURVE_ORDER_RST = 4'd3;
  localparam logic [CFG_W-1:0]   FIELD_SIZE_RST  = 18'd92160;
  localparam logic [CFG_W-1:0]   CENTER_X_RST    = 18'd61440;
  localparam logic [CFG_W-1:0]   CENTER_Y_RST    = 18'd66560;

  typedef enum logic [1:0] {
    HEAD_POS_X = 2'd0,
    HEAD_POS_Y = 2'd1,
    HEAD_NEG_X = 2'd2,
    HEAD_NEG_Y = 2'd3
  } heading_t;

endpackage

/* hdl/hilbert_curve_position.sv */
// Hilbert curve position generator.
// Input stream s_axis: one curve position per transaction, unsigned with
// FRAC_BITS fraction bits. The integer part wraps to the configured cell count.
// Output stream m_axis: interpolated world x and y and the step heading for
// each input transaction, in order.
// Configuration: cfg_we with cfg_addr selects curve_order (0), field_size (1),
// center_x (2) or center_y (3); write only while no transaction is in flight.
// Pipeline: an input register, one pipeline stage per curve level, then
// multiply, world, interpolate and output stages. Throughput: one
// transaction per cycle while the skid register is empty.
// A stalled receiver fills the output register and then a one-entry skid
// register; s_axis_tready drops when the skid register holds data and the
// whole pipeline freezes without losing or repeating a transaction.
// Reset (rst, synchronous) empties the pipeline and loads the default
// configuration: order 3, field 92160, center (61440, 66560).
module hilbert_curve_position #(
  parameter int MAX_ORDER = hcp_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = hcp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,   // [23:0] curve_pos
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,   // [20:0] pos_x, [41:21] pos_y,
                                                      // [43:42] heading, [47:44] zero
  input  logic                        cfg_we,
  input  logic [hcp_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [hcp_pkg::CFG_W-1:0]   cfg_data
);

  import hcp_pkg::*;

  localparam int MO = MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER+1);
  localparam int DW = 2 * MAX_ORDER;

  logic [ORDER_W-1:0] curve_order;
  logic [CFG_W-1:0]   field_size;
  logic [CFG_W-1:0]   center_x;
  logic [CFG_W-1:0]   center_y;

  logic [OW-1:0]      ord;
  logic [DW-1:0]      idx_mask;
  logic [IN_W-1:0]    ipos;
  logic [DW-1:0]      d0_in;
  logic               ce;

  logic               h_valid [0:MO];
  logic [DW-1:0]      h_d0    [0:MO];
  logic [DW-1:0]      h_d1    [0:MO];
  logic [MO-1:0]      h_x0    [0:MO];
  logic [MO-1:0]      h_y0    [0:MO];
  logic [MO-1:0]      h_x1    [0:MO];
  logic [MO-1:0]      h_y1    [0:MO];
  logic [FRAC_BITS-1:0] h_frac [0:MO];

  logic               res_valid;
  logic [OUT_W-1:0]   res_x;
  logic [OUT_W-1:0]   res_y;
  heading_t           res_heading;

  logic               out_valid;
  logic [OUT_W-1:0]   out_x;
  logic [OUT_W-1:0]   out_y;
  heading_t           out_heading;
  logic               skid_valid;
  logic [OUT_W-1:0]   skid_x;
  logic [OUT_W-1:0]   skid_y;
  heading_t           skid_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= CURVE_ORDER_RST;
      field_size  <= FIELD_SIZE_RST;
      center_x    <= CENTER_X_RST;
      center_y    <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CURVE_ORDER: curve_order <= cfg_data[ORDER_W-1:0];
        REG_FIELD_SIZE:  field_size  <= cfg_data;
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Orders above the build limit run as the largest supported order.
  assign ord = ({1'b0, curve_order} > (ORDER_W+1)'(MO)) ? OW'(MO) : OW'(curve_order);
  assign idx_mask = ~({DW{1'b1}} << (2 * ord));
  assign ipos     = s_axis_tdata >> FRAC_BITS;
  assign d0_in    = DW'(ipos) & idx_mask;

  // The pipeline advances whenever the skid register is free.
  assign ce            = !skid_valid;
  assign s_axis_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid[0] <= 1'b0;
    end else if (ce) begin
      h_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h_d0[0]   <= d0_in;
      h_d1[0]   <= (d0_in + DW'(1)) & idx_mask;
      h_x0[0]   <= '0;
      h_y0[0]   <= '0;
      h_x1[0]   <= '0;
      h_y1[0]   <= '0;
      h_frac[0] <= s_axis_tdata[FRAC_BITS-1:0];
    end
  end

  for (genvar l = 0; l < MO; l++) begin : g_level
    hcp_hilbert_stage #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS),
      .LEVEL     (l)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .ord       (ord),
      .in_valid  (h_valid[l]),
      .in_d0     (h_d0[l]),
      .in_d1     (h_d1[l]),
      .in_x0     (h_x0[l]),
      .in_y0     (h_y0[l]),
      .in_x1     (h_x1[l]),
      .in_y1     (h_y1[l]),
      .in_frac   (h_frac[l]),
      .out_valid (h_valid[l+1]),
      .out_d0    (h_d0[l+1]),
      .out_d1    (h_d1[l+1]),
      .out_x0    (h_x0[l+1]),
      .out_y0    (h_y0[l+1]),
      .out_x1    (h_x1[l+1]),
      .out_y1    (h_y1[l+1]),
      .out_frac  (h_frac[l+1])
    );
  end

  hcp_map #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .ord         (ord),
    .field_size  (field_size),
    .center_x    (center_x),
    .center_y    (center_y),
    .in_valid    (h_valid[MO]),
    .in_x0       (h_x0[MO]),
    .in_y0       (h_y0[MO]),
    .in_x1       (h_x1[MO]),
    .in_y1       (h_y1[MO]),
    .in_frac     (h_frac[MO]),
    .res_valid   (res_valid),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_heading (res_heading)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid && out_valid && !m_axis_tready) begin
      skid_valid <= 1'b1;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_x       <= skid_x;
        out_y       <= skid_y;
        out_heading <= skid_heading;
      end
    end else if (res_valid && out_valid && !m_axis_tready) begin
      skid_x       <= res_x;
      skid_y       <= res_y;
      skid_heading <= res_heading;
    end else if (res_valid) begin
      out_x       <= res_x;
      out_y       <= res_y;
      out_heading <= res_heading;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_heading, out_y, out_x};

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds data while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_axis_tready |=> skid_valid && $stable(skid_x) && $stable(skid_y))
    else $error("skid register changed while the receiver stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && m_axis_tready |=> !skid_valid && out_valid)
    else $error("skid register did not drain into the output register");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(h_valid[MO]) && $stable(res_valid))
    else $error("pipeline moved while the skid register was full");
`endif

endmodule

/* hdl/hcp_hilbert_stage.sv */
module hcp_hilbert_stage #(
  parameter int MAX_ORDER = hcp_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = hcp_pkg::FRAC_BITS_DEF,
  parameter int LEVEL     = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  logic [$clog2(MAX_ORDER+1)-1:0]     ord,
  input  logic                               in_valid,
  input  logic [2*MAX_ORDER-1:0]             in_d0,
  input  logic [2*MAX_ORDER-1:0]             in_d1,
  input  logic [MAX_ORDER-1:0]               in_x0,
  input  logic [MAX_ORDER-1:0]               in_y0,
  input  logic [MAX_ORDER-1:0]               in_x1,
  input  logic [MAX_ORDER-1:0]               in_y1,
  input  logic [FRAC_BITS-1:0]               in_frac,
  output logic                               out_valid,
  output logic [2*MAX_ORDER-1:0]             out_d0,
  output logic [2*MAX_ORDER-1:0]             out_d1,
  output logic [MAX_ORDER-1:0]               out_x0,
  output logic [MAX_ORDER-1:0]               out_y0,
  output logic [MAX_ORDER-1:0]               out_x1,
  output logic [MAX_ORDER-1:0]               out_y1,
  output logic [FRAC_BITS-1:0]               out_frac
);

  localparam int MO = MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER+1);
  // Coordinates below this level hold LEVEL bits; XOR with this mask mirrors them.
  localparam logic [MO-1:0] LMASK = MO'((64'd1 << LEVEL) - 64'd1);

  logic          active;
  logic [2*MO-1:0] xy0;
  logic [2*MO-1:0] xy1;

  function automatic logic [2*MO-1:0] step(input logic [1:0] t,
                                          input logic [MO-1:0] x,
                                          input logic [MO-1:0] y);
    logic          rx;
    logic          ry;
    logic [MO-1:0] nx;
    logic [MO-1:0] ny;
    rx = t[1];
    ry = t[0] ^ t[1];
    nx = x;
    ny = y;
    if (!ry) begin
      if (rx) begin
        nx = x ^ LMASK;
        ny = y ^ LMASK;
      end
      {nx, ny} = {ny, nx};
    end
    nx = nx | (MO'(rx) << LEVEL);
    ny = ny | (MO'(ry) << LEVEL);
    return {nx, ny};
  endfunction

  assign active = (ord > OW'(LEVEL));
  assign xy0    = step(in_d0[2*LEVEL +: 2], in_x0, in_y0);
  assign xy1    = step(in_d1[2*LEVEL +: 2], in_x1, in_y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_d0   <= in_d0;
      out_d1   <= in_d1;
      out_frac <= in_frac;
      if (active) begin
        {out_x0, out_y0} <= xy0;
        {out_x1, out_y1} <= xy1;
      end else begin
        out_x0 <= in_x0;
        out_y0 <= in_y0;
        out_x1 <= in_x1;
        out_y1 <= in_y1;
      end
    end
  end

endmodule

/* hdl/hcp_map.sv */
module hcp_map #(
  parameter int MAX_ORDER = hcp_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = hcp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic [$clog2(MAX_ORDER+1)-1:0] ord,
  input  logic [hcp_pkg::CFG_W-1:0]      field_size,
  input  logic [hcp_pkg::CFG_W-1:0]      center_x,
  input  logic [hcp_pkg::CFG_W-1:0]      center_y,
  input  logic                           in_valid,
  input  logic [MAX_ORDER-1:0]           in_x0,
  input  logic [MAX_ORDER-1:0]           in_y0,
  input  logic [MAX_ORDER-1:0]           in_x1,
  input  logic [MAX_ORDER-1:0]           in_y1,
  input  logic [FRAC_BITS-1:0]           in_frac,
  output logic                           res_valid,
  output logic [hcp_pkg::OUT_W-1:0]      res_x,
  output logic [hcp_pkg::OUT_W-1:0]      res_y,
  output hcp_pkg::heading_t              res_heading
);

  import hcp_pkg::*;

  localparam int MO = MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER+1);
  localparam int CW = MO + 2;
  localparam int PW = CW + CFG_W + 1;
  localparam int WW = OUT_W;
  localparam int LW = WW + 1 + FRAC_BITS + 1;

  // Multiply stage: signed cell offsets times field size.
  logic                 m_valid;
  logic signed [PW-1:0] m_px0, m_px1, m_py0, m_py1;
  heading_t             m_heading;
  logic [FRAC_BITS-1:0] m_frac;

  // World stage: cell centers in world coordinates.
  logic                 w_valid;
  logic signed [WW-1:0] w_x0, w_x1, w_y0, w_y1;
  heading_t             w_heading;
  logic [FRAC_BITS-1:0] w_frac;

  // Interpolation stage.
  logic                 l_valid;
  logic signed [WW-1:0] l_x0, l_y0;
  logic signed [LW-1:0] l_dx, l_dy;
  heading_t             l_heading;

  logic [MO-1:0]        nm1;
  logic signed [CW-1:0] cvx0, cvx1, cvy0, cvy1;
  heading_t             heading_next;
  logic [OW:0]          sh;
  logic signed [PW-1:0] sx0, sx1, sy0, sy1;
  logic signed [PW-1:0] fs_ext;
  logic signed [WW-1:0] cx_ext, cy_ext;
  logic signed [WW:0]   diff_x, diff_y;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [LW-1:0] qx, qy;

  assign nm1 = MO'(((MO+1)'(1) << ord) - (MO+1)'(1));

  function automatic logic signed [CW-1:0] cell_off(input logic [MO-1:0] c,
                                                   input logic [MO-1:0] nm);
    return $signed({1'b0, c, 1'b0}) - $signed({2'b00, nm});
  endfunction

  assign cvx0 = cell_off(in_x0, nm1);
  assign cvx1 = cell_off(in_x1, nm1);
  assign cvy0 = cell_off(in_y0, nm1);
  assign cvy1 = cell_off(in_y1, nm1);

  // Direction of the step from the current cell to the next one.
  always_comb begin
    if (in_x1 > in_x0) begin
      heading_next = HEAD_POS_X;
    end else if (in_y1 > in_y0) begin
      heading_next = HEAD_POS_Y;
    end else if (in_x1 < in_x0) begin
      heading_next = HEAD_NEG_X;
    end else if (in_y1 < in_y0) begin
      heading_next = HEAD_NEG_Y;
    end else begin
      heading_next = HEAD_POS_X;
    end
  end

  assign fs_ext = $signed({{(PW-CFG_W){1'b0}}, field_size});

  // Arithmetic shifts floor toward minus infinity, as the offset rule requires.
  assign sh     = (OW+1)'(ord) + (OW+1)'(1);
  assign sx0    = m_px0 >>> sh;
  assign sx1    = m_px1 >>> sh;
  assign sy0    = m_py0 >>> sh;
  assign sy1    = m_py1 >>> sh;
  assign cx_ext = $signed({{(WW-CFG_W){1'b0}}, center_x});
  assign cy_ext = $signed({{(WW-CFG_W){1'b0}}, center_y});

  assign diff_x = {w_x1[WW-1], w_x1} - {w_x0[WW-1], w_x0};
  assign diff_y = {w_y1[WW-1], w_y1} - {w_y0[WW-1], w_y0};
  assign frac_s = $signed({1'b0, w_frac});

  assign qx = l_dx >>> FRAC_BITS;
  assign qy = l_dy >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      w_valid <= 1'b0;
      l_valid <= 1'b0;
    end else if (ce) begin
      m_valid <= in_valid;
      w_valid <= m_valid;
      l_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_px0     <= PW'(cvx0) * fs_ext;
      m_px1     <= PW'(cvx1) * fs_ext;
      m_py0     <= PW'(cvy0) * fs_ext;
      m_py1     <= PW'(cvy1) * fs_ext;
      m_heading <= heading_next;
      m_frac    <= in_frac;

      w_x0      <= cx_ext + WW'(sx0);
      w_x1      <= cx_ext + WW'(sx1);
      w_y0      <= cy_ext + WW'(sy0);
      w_y1      <= cy_ext + WW'(sy1);
      w_heading <= m_heading;
      w_frac    <= m_frac;

      l_x0      <= w_x0;
      l_y0      <= w_y0;
      l_dx      <= LW'(diff_x) * LW'(frac_s);
      l_dy      <= LW'(diff_y) * LW'(frac_s);
      l_heading <= w_heading;
    end
  end

  assign res_valid   = l_valid;
  assign res_x       = OUT_W'(l_x0 + WW'(qx));
  assign res_y       = OUT_W'(l_y0 + WW'(qy));
  assign res_heading = l_heading;

endmodule
